### sv/keyed_fifo_with_removal_top_macros.svh
// assertion macros for the keyed fifo top level
// expects clk and rst_n in the scope of each use
`ifndef KEYED_FIFO_WITH_REMOVAL_TOP_MACROS_SVH
`define KEYED_FIFO_WITH_REMOVAL_TOP_MACROS_SVH

// condition holds in the same cycle as the trigger
`define KFR_ASSERT_NOW(lbl, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
    else $error("keyed fifo check failed");

// condition holds in the cycle after the trigger
`define KFR_ASSERT_NEXT(lbl, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error("keyed fifo check failed");

`endif

### sv/kfr_pkg.sv
// shared constants, codes and structs of the keyed fifo
// no dependencies
package kfr_pkg;

  localparam int DEPTH    = 64;
  localparam int KEY_BITS = 31;
  localparam int IDX_W    = $clog2(DEPTH);
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int LIM_W    = 7;
  localparam int FUNC_W   = 2;
  localparam int ST_W     = 2;
  localparam int CMP_W    = ((CNT_W > LIM_W) ? CNT_W : LIM_W) + 1;

  // operation codes
  localparam logic [FUNC_W-1:0] FN_PUSH   = 2'd0;
  localparam logic [FUNC_W-1:0] FN_REMOVE = 2'd1;
  localparam logic [FUNC_W-1:0] FN_POP    = 2'd2;

  // status codes
  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY     = 2'd2;
  localparam logic [ST_W-1:0] ST_FULL      = 2'd3;

  // update command from control to the entry row
  typedef struct packed {
    logic             upd;
    logic             drop_head;
    logic             drop_match;
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
  } cell_cmd_t;

  // lookup results from the entry row
  typedef struct packed {
    logic                found;
    logic [KEY_BITS-1:0] head_key;
    logic [KEY_BITS-1:0] tail_key;
  } cell_stat_t;

  // one result item
  typedef struct packed {
    logic                evicted;
    logic [KEY_BITS-1:0] key_out;
    logic [ST_W-1:0]     status;
  } result_t;

endpackage

### sv/kfr_if.sv
// valid/ready channel interfaces of the keyed fifo
// depends on kfr_pkg
interface kfr_in_if import kfr_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic [KEY_BITS-1:0] key;

  modport source (output valid, func, key, input ready);
  modport sink (input valid, func, key, output ready);
endinterface

interface kfr_out_if import kfr_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                evicted;
  logic [KEY_BITS-1:0] key_out;
  logic [ST_W-1:0]     status;

  modport source (output valid, evicted, key_out, status, input ready);
  modport sink (input valid, evicted, key_out, status, output ready);
endinterface

interface kfr_cfg_if import kfr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [LIM_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

### sv/kfr_cells.sv
// entry row: key registers oldest first, parallel compare, shift compaction
// depends on kfr_pkg
module kfr_cells import kfr_pkg::*; (
  input  logic                clk,
  input  logic [CNT_W-1:0]    count,
  input  logic [KEY_BITS-1:0] key,
  input  cell_cmd_t           cmd,
  output cell_stat_t          stat
);

  localparam logic [DEPTH-1:0] ALL_ONES = {DEPTH{1'b1}};

  logic [KEY_BITS-1:0] key_r   [DEPTH];
  logic [KEY_BITS-1:0] key_nxt [DEPTH];
  logic [DEPTH-1:0]    hit;
  logic [DEPTH-1:0]    at_or_above;
  logic [DEPTH-1:0]    shift_sel;
  logic [CNT_W-1:0]    tail_pos;
  logic [KEY_BITS-1:0] tail_key;

  // compare every live entry against the key
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      hit[i] = (CNT_W'(i) < count) && (key_r[i] == key);
    end
  end

  // a head drop moves every entry down by one, a match drop the entries at or above the oldest match
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      at_or_above[i] = |(hit & (ALL_ONES >> (DEPTH - 1 - i)));
      shift_sel[i]   = cmd.drop_head | (cmd.drop_match & at_or_above[i]);
    end
  end

  // newest entry, each cell gated onto an or-bus by its own position
  always_comb begin
    tail_pos = count - CNT_W'(1);
    tail_key = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (CNT_W'(i) == tail_pos) begin
        tail_key = tail_key | key_r[i];
      end
    end
  end

  assign stat.found    = at_or_above[DEPTH-1];
  assign stat.head_key = key_r[0];
  assign stat.tail_key = tail_key;

  // compaction then tail write
  always_comb begin
    for (int i = 0; i < DEPTH - 1; i++) begin
      key_nxt[i] = shift_sel[i] ? key_r[i+1] : key_r[i];
    end
    key_nxt[DEPTH-1] = key_r[DEPTH-1];
    for (int i = 0; i < DEPTH; i++) begin
      if (cmd.wr_en && (cmd.wr_idx == IDX_W'(i))) begin
        key_nxt[i] = key;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.upd) begin
      key_r <= key_nxt;
    end
  end

endmodule

### sv/kfr_ctrl.sv
// operation decode, entry count and limit register
// depends on kfr_pkg
module kfr_ctrl import kfr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [LIM_W-1:0]  cfg_data,
  input  logic              upd,
  input  logic [FUNC_W-1:0] func,
  input  cell_stat_t        stat,
  output cell_cmd_t         cmd,
  output logic [CNT_W-1:0]  count,
  output result_t           res
);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [LIM_W-1:0] limit_r;
  logic             full;
  logic             over;
  logic             evict;

  // push decisions
  assign full  = (CMP_W'(count_r) >= CMP_W'(DEPTH));
  assign over  = (limit_r != '0) &&
                 (full || (CMP_W'(count_r) + CMP_W'(1) > CMP_W'(limit_r)));
  assign evict = over && (count_r != '0);

  always_comb begin
    cmd            = '0;
    cmd.upd        = upd;
    res            = '0;
    res.status     = ST_OK;
    count_nxt      = count_r;
    case (func)
      FN_PUSH: begin
        if (full && (limit_r == '0)) begin
          res.status = ST_FULL;
        end else begin
          cmd.wr_en = 1'b1;
          if (evict) begin
            res.evicted   = 1'b1;
            res.key_out   = stat.head_key;
            cmd.drop_head = 1'b1;
            cmd.wr_idx    = IDX_W'(count_r - CNT_W'(1));
          end else begin
            cmd.wr_idx = IDX_W'(count_r);
            count_nxt  = count_r + CNT_W'(1);
          end
        end
      end
      FN_REMOVE: begin
        if (stat.found) begin
          cmd.drop_match = 1'b1;
          count_nxt      = count_r - CNT_W'(1);
        end else begin
          res.status = ST_NOT_FOUND;
        end
      end
      FN_POP: begin
        if (count_r == '0) begin
          res.status = ST_EMPTY;
        end else begin
          res.key_out = stat.tail_key;
          count_nxt   = count_r - CNT_W'(1);
        end
      end
      default: begin
        res = '0;
      end
    endcase
    if (!upd) begin
      cmd.drop_head  = 1'b0;
      cmd.drop_match = 1'b0;
      cmd.wr_en      = 1'b0;
    end
  end

  // count and limit registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      limit_r <= '0;
    end else begin
      if (upd) begin
        count_r <= count_nxt;
      end
      if (cfg_we) begin
        limit_r <= cfg_data;
      end
    end
  end

  assign count = count_r;

endmodule

### sv/keyed_fifo_with_removal_top.sv
// keyed fifo top level: input register, entry row and control, result register
// depends on kfr_pkg, kfr_if, kfr_cells, kfr_ctrl and the macros header
//
//   channel  dir  payload                      transaction when
//   in_ch    in   func, key                    valid && ready
//   out_ch   out  evicted, key_out, status     valid && ready
//   cfg_ch   in   data (entry limit)           valid && ready, ready tied high
//
// one operation per cycle sustained while out_ch is not stalled; a result passes from
// its input transaction through the input register and then the result register,
// around the combinational compare and shift over the entry row
// synchronous active-low reset clears the count, the limit and the valid flags;
// the keys need no clearing since only live entries are ever read
// a stalled result holds the input register, which then drops in_ch.ready
`include "keyed_fifo_with_removal_top_macros.svh"

module keyed_fifo_with_removal_top import kfr_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  kfr_in_if.sink    in_ch,
  kfr_out_if.source out_ch,
  kfr_cfg_if.sink   cfg_ch
);

  logic                s1_valid_r;
  logic [FUNC_W-1:0]   s1_func_r;
  logic [KEY_BITS-1:0] s1_key_r;
  logic                out_valid_r;
  result_t             out_r;
  logic                advance;
  logic                in_fire;
  cell_cmd_t           cmd;
  cell_stat_t          stat;
  logic [CNT_W-1:0]    count;
  result_t             res;

  // handshake
  assign advance      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || advance;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_func_r <= in_ch.func;
      s1_key_r  <= in_ch.key;
    end
  end

  kfr_cells u_cells (
    .clk   (clk),
    .count (count),
    .key   (s1_key_r),
    .cmd   (cmd),
    .stat  (stat)
  );

  kfr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_ch.valid && cfg_ch.ready),
    .cfg_data (cfg_ch.data),
    .upd      (advance),
    .func     (s1_func_r),
    .stat     (stat),
    .cmd      (cmd),
    .count    (count),
    .res      (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= res;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.evicted = out_r.evicted;
  assign out_ch.key_out = out_r.key_out;
  assign out_ch.status  = out_r.status;

  // checks
  `KFR_ASSERT_NEXT(a_advance_loads_result, advance, out_valid_r)
  `KFR_ASSERT_NEXT(a_stage_holds_on_stall, s1_valid_r && !advance,
                   s1_valid_r && $stable(s1_key_r) && $stable(s1_func_r))
  `KFR_ASSERT_NOW(a_evict_is_ok, out_valid_r && out_r.evicted, out_r.status == ST_OK)
  `KFR_ASSERT_NOW(a_reject_is_quiet, out_valid_r && (out_r.status == ST_FULL),
                  !out_r.evicted && (out_r.key_out == '0))

endmodule
